// ===== rtl/rgb_to_hsv_converter_assert.svh =====
// Assertion macros for the checker file rhc_checker.sv.
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RHC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_converter: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_to_hsv_converter: next-cycle check failed");

`endif

// ===== rtl/rhc_pkg.sv =====
`default_nettype none

package rhc_pkg;

    localparam int PIX_W       = 8;
    localparam int HUE_W       = 15;
    localparam int SV_W        = 13;
    localparam int DEG_W       = 9;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - HUE_W - 2 * SV_W;

    localparam int HUE_SPAN    = 60;
    localparam int PCT_SCALE   = 100;
    localparam int FULL_SCALE  = 255;

    // divider lanes; value uses a reciprocal multiply instead
    localparam int NUM_LANES   = 2;
    localparam int LANE_HUE    = 0;
    localparam int LANE_SAT    = 1;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pix_t;

    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [SV_W-1:0]      val;
        logic [SV_W-1:0]      sat;
        logic [HUE_W-1:0]     hue;
    } out_word_t;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    typedef enum logic [1:0] {
        BASE_0,
        BASE_120,
        BASE_240,
        BASE_360
    } hue_base_t;

    // Per-pixel control carried alongside the divider lanes
    typedef struct packed {
        hue_base_t base;
        logic      neg;    // hue = base - ceil(q) instead of base + q
        logic      grey;   // delta is zero
        logic      black;  // max is zero
    } side_t;

    typedef struct packed {
        logic [PIX_W-1:0] rem;
        logic             qbit;
    } div_step_t;

    function automatic logic [DEG_W-1:0] base_deg(input hue_base_t code);
        logic [DEG_W-1:0] deg;
        unique case (code)
            BASE_0:   deg = DEG_W'(0);
            BASE_120: deg = DEG_W'(120);
            BASE_240: deg = DEG_W'(240);
            BASE_360: deg = DEG_W'(360);
            default:  deg = DEG_W'(0);
        endcase
        return deg;
    endfunction

    // One restoring-division step: shift in one dividend bit, subtract if it fits.
    function automatic div_step_t div_step(input logic [PIX_W-1:0] rem,
                                           input logic             din,
                                           input logic [PIX_W-1:0] dv);
        logic [PIX_W:0] t;
        logic [PIX_W:0] d;
        div_step_t      s;
        t = {rem, din};
        d = {1'b0, dv};
        if (t >= d)
        begin
            s.rem  = PIX_W'(t - d);
            s.qbit = 1'b1;
        end
        else
        begin
            s.rem  = t[PIX_W-1:0];
            s.qbit = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb_to_hsv_converter.sv =====
// Throughput: one pixel per clock while the output is not stalled; the divider lanes
// resolve one quotient bit per stage.
// A stalled output freezes the whole pipeline; a one-word skid buffer keeps
// the input side ready for one more word while the output waits.
// Reset (rst_n low, asynchronous) clears all valid bits and the skid buffer.
`default_nettype none

module rgb_to_hsv_converter #(
    parameter int FRAC_BITS = 6
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  wire logic [rhc_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [14:0] hue_out, [27:15] sat_out, [40:28] val_out, [47:41] zero
    output logic [rhc_pkg::OUT_TDATA_W-1:0]            m_axis_tdata
);
    import rhc_pkg::*;

    localparam int QW = FRAC_BITS + 7;
    localparam int NW = QW + PIX_W;

    logic             en;
    pix_t             s_pix;
    out_word_t        m_word;

    logic             fr_valid;
    side_t            fr_side;
    logic [NW-1:0]    hue_num, sat_num;
    logic [QW-1:0]    fr_val;
    logic [PIX_W-1:0] hue_dv, sat_dv;

    logic             dq_valid;
    side_t            dq_side;
    logic [QW-1:0]    hue_q, sat_q, val_q;
    logic             hue_rem_nz;

    logic [HUE_W-1:0] hue;
    logic [SV_W-1:0]  sat, val;

    assign en    = !m_axis_tvalid || m_axis_tready;
    assign s_pix = pix_t'(s_axis_tdata);

    rhc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_pix     (s_pix),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .hue_num   (hue_num),
        .sat_num   (sat_num),
        .val_q     (fr_val),
        .hue_dv    (hue_dv),
        .sat_dv    (sat_dv)
    );

    rhc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (fr_valid),
        .in_side    (fr_side),
        .hue_num    (hue_num),
        .sat_num    (sat_num),
        .val_in     (fr_val),
        .hue_dv     (hue_dv),
        .sat_dv     (sat_dv),
        .out_valid  (dq_valid),
        .out_side   (dq_side),
        .hue_q      (hue_q),
        .sat_q      (sat_q),
        .val_q      (val_q),
        .hue_rem_nz (hue_rem_nz)
    );

    rhc_post #(.FRAC_BITS(FRAC_BITS)) u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (dq_valid),
        .in_side    (dq_side),
        .hue_q      (hue_q),
        .sat_q      (sat_q),
        .val_q      (val_q),
        .hue_rem_nz (hue_rem_nz),
        .out_valid  (m_axis_tvalid),
        .hue        (hue),
        .sat        (sat),
        .val        (val)
    );

    always_comb
    begin
        m_word.pad = '0;
        m_word.val = val;
        m_word.sat = sat;
        m_word.hue = hue;
    end

    assign m_axis_tdata = m_word;

endmodule

`default_nettype wire

// ===== rtl/rhc_front.sv =====
`default_nettype none

module rhc_front #(
    parameter int FRAC_BITS = 6
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          en,
    input  wire logic                                          s_valid,
    output logic                                               s_ready,
    input  wire rhc_pkg::pix_t                                 s_pix,
    output logic                                               out_valid,
    output rhc_pkg::side_t                                     out_side,
    output logic [FRAC_BITS+7+rhc_pkg::PIX_W-1:0]              hue_num,
    output logic [FRAC_BITS+7+rhc_pkg::PIX_W-1:0]              sat_num,
    output logic [FRAC_BITS+6:0]                               val_q,
    output logic [rhc_pkg::PIX_W-1:0]                          hue_dv,
    output logic [rhc_pkg::PIX_W-1:0]                          sat_dv
);
    import rhc_pkg::*;

    localparam int QW = FRAC_BITS + 7;
    localparam int NW = QW + PIX_W;

    // value = max * 100 * 2^FRAC_BITS / 255 by reciprocal multiply;
    // 16 guard bits keep max * rounding error below one unit
    localparam int     VAL_SH     = 16;
    localparam int     PW         = PIX_W + NW;
    localparam longint VAL_K_FULL = ((longint'(PCT_SCALE) << (FRAC_BITS + VAL_SH))
                                     + longint'(FULL_SCALE - 1)) / longint'(FULL_SCALE);
    localparam logic [NW-1:0] VAL_K = NW'(VAL_K_FULL);

    // skid word
    logic             skid_valid_reg, skid_valid_next;
    pix_t             skid_pix_reg;
    logic             in_fire;
    logic             src_valid;
    pix_t             src_pix;

    // stage 1: max / min / sector
    logic             v1_reg;
    pix_t             pix1_reg;
    logic [PIX_W-1:0] mx1_reg, mx1_next;
    logic [PIX_W-1:0] mn1_reg, mn1_next;
    sector_t          sec1_reg, sec1_next;

    // stage 2: delta, signed difference split into magnitude and sign
    logic             v2_reg;
    logic [PIX_W-1:0] mx2_reg;
    logic [PIX_W-1:0] delta2_reg, delta2_next;
    logic [PIX_W-1:0] dabs2_reg, dabs2_next;
    side_t            side2_reg, side2_next;
    logic [QW-1:0]    val2_reg, val2_next;
    logic [PW-1:0]    val_prod;
    logic [PIX_W-1:0] op_a, op_b;
    logic             neg;

    assign s_ready   = !skid_valid_reg;
    assign in_fire   = s_valid && !skid_valid_reg;
    assign src_valid = skid_valid_reg || in_fire;
    assign src_pix   = skid_valid_reg ? skid_pix_reg : s_pix;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (en)
            skid_valid_next = 1'b0;
        else if (in_fire)
            skid_valid_next = 1'b1;
    end

    // ties: red wins over green, green over blue
    always_comb
    begin
        if (src_pix.red >= src_pix.green && src_pix.red >= src_pix.blue)
        begin
            sec1_next = SEC_RED;
            mx1_next  = src_pix.red;
        end
        else if (src_pix.green >= src_pix.blue)
        begin
            sec1_next = SEC_GREEN;
            mx1_next  = src_pix.green;
        end
        else
        begin
            sec1_next = SEC_BLUE;
            mx1_next  = src_pix.blue;
        end
        mn1_next = src_pix.red;
        if (src_pix.green < mn1_next)
            mn1_next = src_pix.green;
        if (src_pix.blue < mn1_next)
            mn1_next = src_pix.blue;
    end

    always_comb
    begin
        unique case (sec1_reg)
            SEC_RED:
            begin
                op_a = pix1_reg.green;
                op_b = pix1_reg.blue;
            end
            SEC_GREEN:
            begin
                op_a = pix1_reg.blue;
                op_b = pix1_reg.red;
            end
            SEC_BLUE:
            begin
                op_a = pix1_reg.red;
                op_b = pix1_reg.green;
            end
            default:
            begin
                op_a = pix1_reg.red;
                op_b = pix1_reg.green;
            end
        endcase

        neg = (op_a < op_b);
        if (neg)
            dabs2_next = op_b - op_a;
        else
            dabs2_next = op_a - op_b;

        delta2_next      = mx1_reg - mn1_reg;
        side2_next.neg   = neg;
        side2_next.grey  = (mx1_reg == mn1_reg);
        side2_next.black = (mx1_reg == '0);
        unique case (sec1_reg)
            SEC_RED:   side2_next.base = neg ? BASE_360 : BASE_0;
            SEC_GREEN: side2_next.base = BASE_120;
            SEC_BLUE:  side2_next.base = BASE_240;
            default:   side2_next.base = BASE_0;
        endcase

        val_prod  = PW'(mx1_reg) * PW'(VAL_K);
        val2_next = val_prod[VAL_SH +: QW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
            if (en)
            begin
                v1_reg <= src_valid;
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && in_fire)
            skid_pix_reg <= s_pix;
        if (en)
        begin
            pix1_reg   <= src_pix;
            mx1_reg    <= mx1_next;
            mn1_reg    <= mn1_next;
            sec1_reg   <= sec1_next;
            mx2_reg    <= mx1_reg;
            delta2_reg <= delta2_next;
            dabs2_reg  <= dabs2_next;
            side2_reg  <= side2_next;
            val2_reg   <= val2_next;
        end
    end

    // dividends scaled by 2^FRAC_BITS; each quotient fits in QW bits
    assign hue_num   = NW'(NW'(dabs2_reg) * NW'(HUE_SPAN)) << FRAC_BITS;
    assign sat_num   = NW'(NW'(delta2_reg) * NW'(PCT_SCALE)) << FRAC_BITS;
    assign val_q     = val2_reg;
    assign hue_dv    = delta2_reg;
    assign sat_dv    = mx2_reg;
    assign out_valid = v2_reg;
    assign out_side  = side2_reg;

endmodule

`default_nettype wire

// ===== rtl/rhc_div.sv =====
`default_nettype none

module rhc_div #(
    parameter int FRAC_BITS = 6
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic                                  in_valid,
    input  wire rhc_pkg::side_t                        in_side,
    input  wire logic [FRAC_BITS+7+rhc_pkg::PIX_W-1:0] hue_num,
    input  wire logic [FRAC_BITS+7+rhc_pkg::PIX_W-1:0] sat_num,
    input  wire logic [FRAC_BITS+6:0]                  val_in,
    input  wire logic [rhc_pkg::PIX_W-1:0]             hue_dv,
    input  wire logic [rhc_pkg::PIX_W-1:0]             sat_dv,
    output logic                                       out_valid,
    output rhc_pkg::side_t                             out_side,
    output logic [FRAC_BITS+6:0]                       hue_q,
    output logic [FRAC_BITS+6:0]                       sat_q,
    output logic [FRAC_BITS+6:0]                       val_q,
    output logic                                       hue_rem_nz
);
    import rhc_pkg::*;

    localparam int QW = FRAC_BITS + 7;
    localparam int NW = QW + PIX_W;

    // Stage 0 loads the dividends; stage k holds k quotient bits per lane.
    logic [PIX_W-1:0] rem_reg  [0:QW][NUM_LANES];
    logic [PIX_W-1:0] rem_next [0:QW][NUM_LANES];
    logic [QW-1:0]    q_reg    [0:QW][NUM_LANES];
    logic [QW-1:0]    q_next   [0:QW][NUM_LANES];
    logic [QW-1:0]    low_reg  [0:QW-1][NUM_LANES];
    logic [QW-1:0]    low_next [0:QW-1][NUM_LANES];
    logic [PIX_W-1:0] dv_reg   [0:QW-1][NUM_LANES];
    logic [PIX_W-1:0] dv_next  [0:QW-1][NUM_LANES];
    logic [QW-1:0]    vq_reg   [0:QW];
    side_t            side_reg [0:QW];
    logic [QW:0]      valid_reg;
    logic [NW-1:0]    num      [NUM_LANES];

    assign num[LANE_HUE] = hue_num;
    assign num[LANE_SAT] = sat_num;

    always_comb
    begin
        div_step_t st;
        dv_next[0][LANE_HUE] = hue_dv;
        dv_next[0][LANE_SAT] = sat_dv;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            // upper dividend bits are below the divisor, so no quotient bit there
            rem_next[0][l] = num[l][NW-1:QW];
            low_next[0][l] = num[l][QW-1:0];
            q_next[0][l]   = '0;
        end
        for (int k = 1; k <= QW; k++)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                st = div_step(rem_reg[k-1][l], low_reg[k-1][l][QW-1], dv_reg[k-1][l]);
                rem_next[k][l] = st.rem;
                q_next[k][l]   = {q_reg[k-1][l][QW-2:0], st.qbit};
            end
        end
        for (int k = 1; k < QW; k++)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                low_next[k][l] = {low_reg[k-1][l][QW-2:0], 1'b0};
                dv_next[k][l]  = dv_reg[k-1][l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[QW-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            vq_reg[0]   <= val_in;
            for (int k = 1; k <= QW; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                vq_reg[k]   <= vq_reg[k-1];
            end
            rem_reg <= rem_next;
            q_reg   <= q_next;
            low_reg <= low_next;
            dv_reg  <= dv_next;
        end
    end

    assign out_valid  = valid_reg[QW];
    assign out_side   = side_reg[QW];
    assign hue_q      = q_reg[QW][LANE_HUE];
    assign sat_q      = q_reg[QW][LANE_SAT];
    assign val_q      = vq_reg[QW];
    assign hue_rem_nz = (rem_reg[QW][LANE_HUE] != '0);

endmodule

`default_nettype wire

// ===== rtl/rhc_post.sv =====
`default_nettype none

module rhc_post #(
    parameter int FRAC_BITS = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire rhc_pkg::side_t              in_side,
    input  wire logic [FRAC_BITS+6:0]        hue_q,
    input  wire logic [FRAC_BITS+6:0]        sat_q,
    input  wire logic [FRAC_BITS+6:0]        val_q,
    input  wire logic                        hue_rem_nz,
    output logic                             out_valid,
    output logic [rhc_pkg::HUE_W-1:0]        hue,
    output logic [rhc_pkg::SV_W-1:0]         sat,
    output logic [rhc_pkg::SV_W-1:0]         val
);
    import rhc_pkg::*;

    localparam int QW  = FRAC_BITS + 7;
    localparam int BW  = FRAC_BITS + DEG_W;
    localparam int HFW = (BW > HUE_W) ? BW : HUE_W;
    localparam int SFW = (QW > SV_W) ? QW : SV_W;

    logic             valid_reg;
    logic [HUE_W-1:0] hue_reg, hue_next;
    logic [SV_W-1:0]  sat_reg, sat_next;
    logic [SV_W-1:0]  val_reg, val_next;
    logic [BW-1:0]    base_s;
    logic [BW-1:0]    hue_full;
    logic [HFW-1:0]   hue_x;
    logic [SFW-1:0]   sat_x;
    logic [SFW-1:0]   val_x;

    assign base_s = BW'(base_deg(in_side.base)) << FRAC_BITS;

    // negative ratio: base minus the ceiling of the magnitude quotient
    always_comb
    begin
        if (in_side.grey)
            hue_full = '0;
        else if (in_side.neg)
            hue_full = base_s - BW'(hue_q) - BW'(hue_rem_nz);
        else
            hue_full = base_s + BW'(hue_q);
        hue_x    = HFW'(hue_full);
        sat_x    = SFW'(sat_q);
        val_x    = SFW'(val_q);
        hue_next = hue_x[HUE_W-1:0];
        sat_next = in_side.black ? '0 : sat_x[SV_W-1:0];
        val_next = val_x[SV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= val_next;
        end
    end

    assign out_valid = valid_reg;
    assign hue       = hue_reg;
    assign sat       = sat_reg;
    assign val       = val_reg;

endmodule

`default_nettype wire

// ===== rtl/rhc_checker.sv =====
`default_nettype none
`include "rgb_to_hsv_converter_assert.svh"

module rhc_checker #(
    parameter int FRAC_BITS = 6
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [rhc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import rhc_pkg::*;

    // full ranges fit the field widths only up to 6 fraction bits
    localparam bit RANGE_ON = (FRAC_BITS <= 6);
    // a nonzero max gives a nonzero value only from 2 fraction bits on
    localparam bit BLACK_ON = (FRAC_BITS >= 2) && (FRAC_BITS <= 6);
    localparam int HUE_MAX  = 360 * (1 << FRAC_BITS) - 1;
    localparam int PCT_MAX  = PCT_SCALE * (1 << FRAC_BITS);

    out_word_t mw;

    assign mw = out_word_t'(m_axis_tdata);

    `RHC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

    // input side only backs off after an output stall
    `RHC_ASSERT_NOW(a_skid_cause, !s_axis_tready,
        $past(m_axis_tvalid && !m_axis_tready))

    `RHC_ASSERT_NOW(a_range, RANGE_ON && m_axis_tvalid,
        (int'(mw.hue) <= HUE_MAX) && (int'(mw.sat) <= PCT_MAX)
        && (int'(mw.val) <= PCT_MAX) && (mw.pad == '0))

    `RHC_ASSERT_NOW(a_black, BLACK_ON && m_axis_tvalid && (mw.val == '0),
        (mw.hue == '0) && (mw.sat == '0))

endmodule

bind rgb_to_hsv_converter rhc_checker #(.FRAC_BITS(FRAC_BITS)) u_rhc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
